// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the heightmap sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/hmtri_pkg.sv =====
// Package: register indexes and fixed-point constants of the heightmap sampler.
`timescale 1ns / 1ps
package hmtri_pkg;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE = 2'd3;

    localparam logic [8:0] GRID_RESET = 9'd256;
    localparam logic [30:0] SCALE_RESET = 31'd65536;

    // One in Q1.16, as an 18-bit signed weight.
    localparam logic signed [17:0] W_ONE = 18'sd65536;
    localparam logic [15:0] FRAC_MAX = 16'hFFFF;

    localparam logic [1:0] SEL_LOW_GT = 2'b11;
    localparam logic [1:0] SEL_HIGH_GT = 2'b01;
    localparam logic [1:0] SEL_HIGH_LE = 2'b00;
    localparam logic [1:0] SEL_LOW_LE = 2'b10;
endpackage

// ===== rtl/hmtri_bank.sv =====
// Height sample bank: one write port, two registered read ports.
`timescale 1ns / 1ps
module hmtri_bank
    import hmtri_pkg::*;
#(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW = 15,
    parameter int unsigned DW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read first: data written at an earlier edge is seen.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule

// ===== rtl/heightmap_triangle_height_sample.sv =====
// Top level: heightmap store and triangle height sampler pipeline.
`timescale 1ns / 1ps
// Usage
//   Input channel i_valid / o_stall: a beat with i_func = 0 writes one height sample
//   at (i_sample_col, i_sample_row); a beat with i_func = 1 queries (i_pos_x, i_pos_z).
//   Output channel o_valid / i_stall: one beat per query, none per write, in order.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx (cols, rows,
//   cell scale, inverse scale); write only while the pipe is empty.
// Timing
//   One beat accepted per cycle while o_stall is low. A query's result passes a pipe
//   whose depth is set by the 31x31 position multiplier, the registered sample read,
//   the triangle products and the split scaling multiply.
//   The four corners of a cell come from two banks (even and odd rows), each read
//   at two columns per cycle; writes reach the banks in the same stage as reads,
//   so a query always sees every write accepted before it.
// Reset
//   Clears all valid flags and loads 256 x 256 grid and unity scales. The sample
//   store is not cleared: reading a never-written sample gives an undefined height.
// Backpressure
//   When a result is held by i_stall, the whole pipe holds and o_stall rises;
//   nothing is dropped or repeated.
`include "assert_macros.svh"
module heightmap_triangle_height_sample
    import hmtri_pkg::*;
#(
    parameter int unsigned MAX_COLS = 256,
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned HEIGHT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic [7:0]            i_sample_col,
    input  logic [7:0]            i_sample_row,
    input  logic signed [15:0]    i_sample_height,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_new_y,
    output logic                  o_on_terrain,
    output logic                  o_saturated
);
    localparam int unsigned HB = HEIGHT_BITS;
    localparam int unsigned TW = HEIGHT_BITS + 20;
    localparam int unsigned MHW = TW - 24;
    localparam int unsigned QW = MHW + 32;
    localparam int unsigned CW = $clog2(MAX_COLS);
    localparam int unsigned RW = $clog2(MAX_ROWS);
    localparam int unsigned CLW = $clog2(MAX_COLS + 1);
    localparam int unsigned RLW = $clog2(MAX_ROWS + 1);
    localparam int unsigned BANK_DEPTH = ((MAX_ROWS + 1) / 2) * MAX_COLS;
    localparam int unsigned AW = $clog2(BANK_DEPTH);

    // Configuration and derived grid limits
    logic [8:0]  r_grid_cols, r_grid_rows;
    logic [30:0] r_cell_scale, r_inv_scale;
    logic [CLW-1:0] r_cols, n_cols;
    logic [RLW-1:0] r_rows, n_rows;
    logic [CLW+30:0] r_ex;
    logic [RLW+30:0] r_ez;
    logic r_grid_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_RESET;
            r_grid_rows <= GRID_RESET;
            r_cell_scale <= SCALE_RESET;
            r_inv_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_COLS:  r_grid_cols <= i_cfg_data[8:0];
                CFG_GRID_ROWS:  r_grid_rows <= i_cfg_data[8:0];
                CFG_CELL_SCALE: r_cell_scale <= i_cfg_data;
                CFG_INV_SCALE:  r_inv_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_cols = (32'(r_grid_cols) > MAX_COLS) ? CLW'(MAX_COLS) : CLW'(r_grid_cols);
        n_rows = (32'(r_grid_rows) > MAX_ROWS) ? RLW'(MAX_ROWS) : RLW'(r_grid_rows);
    end

    // Refresh the limits every cycle; config settles while the block is idle.
    always_ff @(posedge i_clk) begin
        r_cols <= n_cols;
        r_rows <= n_rows;
        r_ex <= (CLW + 31)'((n_cols - CLW'(1)) * r_cell_scale);
        r_ez <= (RLW + 31)'((n_rows - RLW'(1)) * r_cell_scale);
        r_grid_ok <= (n_cols >= CLW'(2)) && (n_rows >= RLW'(2));
    end

    // Pipe control: every stage advances together unless the result is held.
    logic adv;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Stage 1: accepted beat
    logic r1_v, r1_func;
    logic [7:0] r1_col, r1_row;
    logic signed [15:0] r1_h;
    logic signed [31:0] r1_px, r1_py, r1_pz;
    // Stage 2: scaled positions
    logic r2_v, r2_func, r2_in;
    logic [7:0] r2_col, r2_row;
    logic signed [15:0] r2_h;
    logic signed [31:0] r2_py;
    logic [61:0] r2_ux, r2_uz;
    // Stage 3: corner reads
    logic r3_v, r3_in, r3_par;
    logic signed [31:0] r3_py;
    logic [15:0] r3_rx, r3_rz;
    // Stage 4: triangle heights
    logic r4_v, r4_in;
    logic [1:0] r4_sel;
    logic signed [31:0] r4_py;
    logic signed [TW-1:0] r4_t1, r4_t2, r4_t3, r4_t4;
    // Stage 5: chosen height
    logic r5_v, r5_in;
    logic signed [31:0] r5_py;
    logic signed [TW-1:0] r5_h;
    // Stage 6: scaled partial products
    logic r6_v, r6_in, r6_neg;
    logic signed [31:0] r6_py;
    logic [MHW+30:0] r6_ph;
    logic [54:0] r6_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v && r2_func;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // Stage 1 -> 2: inside test and position times inverse scale
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_func <= i_func;
            r1_col <= i_sample_col;
            r1_row <= i_sample_row;
            r1_h <= i_sample_height;
            r1_px <= i_pos_x;
            r1_py <= i_pos_y;
            r1_pz <= i_pos_z;
            r2_func <= r1_func;
            r2_col <= r1_col;
            r2_row <= r1_row;
            r2_h <= r1_h;
            r2_py <= r1_py;
            r2_in <= r_grid_ok && (r1_px > 32'sd0) && (r1_pz > 32'sd0)
                && ((CLW + 31)'(r1_px[30:0]) < r_ex)
                && ((RLW + 31)'(r1_pz[30:0]) < r_ez);
            r2_ux <= r1_px[30:0] * r_inv_scale;
            r2_uz <= r1_pz[30:0] * r_inv_scale;
        end
    end

    // Stage 2: cell index, fraction, bank addresses and sample writes
    logic [29:0] ix, iz;
    logic [CW-1:0] tx, tx1;
    logic [RW-1:0] tz, tz1, row_even, row_odd;
    logic [15:0] rx, rz;
    logic [AW-1:0] ra_e0, ra_e1, ra_o0, ra_o1, wa;
    logic we_ok;
    logic [HB-1:0] wdata;

    always_comb begin
        ix = r2_ux[61:32];
        iz = r2_uz[61:32];
        rx = r2_ux[31:16];
        rz = r2_uz[31:16];
        tx = CW'(ix);
        tz = RW'(iz);
        if (32'(ix) > 32'(r_cols) - 32'd2) begin
            tx = CW'(32'(r_cols) - 32'd2);
            rx = FRAC_MAX;
        end
        if (32'(iz) > 32'(r_rows) - 32'd2) begin
            tz = RW'(32'(r_rows) - 32'd2);
            rz = FRAC_MAX;
        end
        tx1 = tx + CW'(1);
        tz1 = tz + RW'(1);
        row_even = tz[0] ? tz1 : tz;
        row_odd = tz[0] ? tz : tz1;
        ra_e0 = AW'(int'(row_even >> 1) * MAX_COLS + int'(tx));
        ra_e1 = AW'(int'(row_even >> 1) * MAX_COLS + int'(tx1));
        ra_o0 = AW'(int'(row_odd >> 1) * MAX_COLS + int'(tx));
        ra_o1 = AW'(int'(row_odd >> 1) * MAX_COLS + int'(tx1));
        // drop writes beyond the stored grid
        we_ok = r2_v && !r2_func && (32'(r2_col) < MAX_COLS) && (32'(r2_row) < MAX_ROWS);
        wa = AW'(int'(r2_row >> 1) * MAX_COLS + int'(r2_col));
        wdata = HB'(r2_h);
    end

    logic [HB-1:0] rd_e0, rd_e1, rd_o0, rd_o1;

    hmtri_bank #(.DEPTH(BANK_DEPTH), .AW(AW), .DW(HB)) u_bank_even (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_we      (we_ok && !r2_row[0]),
        .i_waddr   (wa),
        .i_wdata   (wdata),
        .i_raddr_a (ra_e0),
        .i_raddr_b (ra_e1),
        .o_rdata_a (rd_e0),
        .o_rdata_b (rd_e1)
    );

    hmtri_bank #(.DEPTH(BANK_DEPTH), .AW(AW), .DW(HB)) u_bank_odd (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_we      (we_ok && r2_row[0]),
        .i_waddr   (wa),
        .i_wdata   (wdata),
        .i_raddr_a (ra_o0),
        .i_raddr_b (ra_o1),
        .o_rdata_a (rd_o0),
        .o_rdata_b (rd_o1)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_in <= r2_in;
            r3_par <= tz[0];
            r3_py <= r2_py;
            r3_rx <= rx;
            r3_rz <= rz;
        end
    end

    // Stage 3: four triangle interpolations, z1*(1-a-b) + z2*a + z3*b
    function automatic logic signed [TW-1:0] f_tri(
        input logic signed [HB-1:0] z3,
        input logic signed [HB-1:0] z1,
        input logic signed [HB-1:0] z2,
        input logic signed [17:0]   a,
        input logic signed [17:0]   b
    );
        logic signed [17:0] w;
        logic signed [TW-1:0] p1, p2, p3;
        w = W_ONE - a - b;
        p1 = z1 * w;
        p2 = z2 * a;
        p3 = z3 * b;
        return p1 + p2 + p3;
    endfunction

    logic signed [HB-1:0] g00, g10, g01, g11;
    logic signed [17:0] wrx, wrz, wcx, wcz;
    logic [16:0] rsum;

    always_comb begin
        g00 = r3_par ? rd_o0 : rd_e0;
        g10 = r3_par ? rd_o1 : rd_e1;
        g01 = r3_par ? rd_e0 : rd_o0;
        g11 = r3_par ? rd_e1 : rd_o1;
        wrx = signed'({2'b00, r3_rx});
        wrz = signed'({2'b00, r3_rz});
        wcx = W_ONE - wrx;
        wcz = W_ONE - wrz;
        rsum = {1'b0, r3_rx} + {1'b0, r3_rz};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_in <= r3_in;
            r4_py <= r3_py;
            r4_sel <= {rsum <= 17'd65536, r3_rx > r3_rz};
            r4_t1 <= f_tri(g01, g00, g10, wrx, wrz);
            r4_t2 <= f_tri(g00, g10, g11, wrz, wcx);
            r4_t3 <= f_tri(g10, g11, g01, wcx, wcz);
            r4_t4 <= f_tri(g11, g01, g00, wcz, wrx);
        end
    end

    // Stage 4: the greater of the pair that the case picks
    logic signed [TW-1:0] ha, hb;

    always_comb begin
        unique case (r4_sel)
            SEL_LOW_GT: begin
                ha = r4_t1;
                hb = r4_t2;
            end
            SEL_HIGH_GT: begin
                ha = r4_t2;
                hb = r4_t3;
            end
            SEL_HIGH_LE: begin
                ha = r4_t3;
                hb = r4_t4;
            end
            SEL_LOW_LE: begin
                ha = r4_t4;
                hb = r4_t1;
            end
            default: begin
                ha = r4_t1;
                hb = r4_t1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_in <= r4_in;
            r5_py <= r4_py;
            r5_h <= (ha > hb) ? ha : hb;
        end
    end

    // Stage 5: magnitude times cell size, split at bit 24
    logic [TW-1:0] mag_h;

    assign mag_h = r5_h[TW-1] ? TW'(-r5_h) : TW'(r5_h);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_in <= r5_in;
            r6_py <= r5_py;
            r6_neg <= r5_h[TW-1];
            r6_ph <= mag_h[TW-1:24] * r_cell_scale;
            r6_pl <= mag_h[23:0] * r_cell_scale;
        end
    end

    // Stage 6: floor, saturate, pass the input y through off terrain, output register
    logic [QW-1:0] q, qmag;
    logic rem;
    logic signed [31:0] y;
    logic sat;

    always_comb begin
        q = QW'(r6_ph) + QW'(r6_pl[54:24]);
        rem = |r6_pl[23:0];
        qmag = q + QW'(rem);
        sat = 1'b0;
        if (!r6_neg) begin
            if (q > QW'(32'h7FFF_FFFF)) begin
                y = 32'sh7FFF_FFFF;
                sat = 1'b1;
            end else begin
                y = signed'(q[31:0]);
            end
        end else begin
            if (qmag > QW'(33'h0_8000_0000)) begin
                y = signed'(32'h8000_0000);
                sat = 1'b1;
            end else begin
                y = signed'(32'd0 - qmag[31:0]);
            end
        end
        if (!r6_in) begin
            y = r6_py;
            sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_new_y <= y;
            o_on_terrain <= r6_in;
            o_saturated <= sat;
        end
    end

    `ASSERT_IMP(a_offgrid_nosat, i_clk, i_rst_n, o_valid && !o_on_terrain, !o_saturated)
    `ASSERT_IMP(a_sat_at_rail, i_clk, i_rst_n, o_valid && o_saturated,
        o_new_y == 32'sh7FFF_FFFF || o_new_y == signed'(32'h8000_0000))
    `ASSERT_IMP(a_stall_from_out, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ASSERT_NXT(a_held_result, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_new_y))
endmodule
